>>> rtl/grrq_pkg.sv
// grrq_pkg: shared types and constants for the grouped round-robin thread queues.
// Holds field widths, mode and status codes, sequencer states and the result beat.
// No dependencies.
package grrq_pkg;

  localparam int MAX_GROUPS_DEF  = 16;
  localparam int MAX_THREADS_DEF = 16;

  localparam int MODE_W = 2;
  localparam int GID_W  = 16;
  localparam int TID_W  = 22;
  localparam int STAT_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_CREATE = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SWITCH = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_DUPLICATE  = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_QUEUE_FULL = 3'd4,
    ST_NOTHING    = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GRD,
    S_GCHK,
    S_HCHK,
    S_DRD,
    S_DCHK,
    S_DEL,
    S_SROT,
    S_WAKE,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t          status;
    logic             wake_valid;
    logic [TID_W-1:0] wake_thread;
    logic             caller_sleeps;
    logic             group_created;
    logic             group_removed;
  } res_t;

endpackage

>>> rtl/grrq_ram.sv
// grrq_ram: simple dual-port synchronous RAM, one write and one registered read.
// Used for the group table and the thread store. No dependencies.
module grrq_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/grrq_ctrl.sv
// grrq_ctrl: sequencer that walks the group table and thread store, does the
// read-modify-write for create, delete and switch commands and holds the result beat.
// Depends on grrq_pkg; drives two grrq_ram instances.
module grrq_ctrl import grrq_pkg::*; #(
  parameter int MAX_GROUPS            = MAX_GROUPS_DEF,
  parameter int MAX_THREADS_PER_GROUP = MAX_THREADS_DEF,
  localparam int GW  = $clog2(MAX_GROUPS),
  localparam int HW  = $clog2(MAX_THREADS_PER_GROUP),
  localparam int CW  = $clog2(MAX_THREADS_PER_GROUP + 1),
  localparam int AW  = $clog2(MAX_GROUPS * MAX_THREADS_PER_GROUP),
  localparam int GMW = GID_W + HW + CW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [GID_W-1:0]  in_group_id,
  input  logic [TID_W-1:0]  in_thread_id,
  output logic              out_valid,
  input  logic              out_stall,
  output res_t              out_res,
  output logic              g_we,
  output logic [GW-1:0]     g_waddr,
  output logic [GMW-1:0]    g_wdata,
  output logic [GW-1:0]     g_raddr,
  input  logic [GMW-1:0]    g_rdata,
  output logic              s_we,
  output logic [AW-1:0]     s_waddr,
  output logic [TID_W-1:0]  s_wdata,
  output logic [AW-1:0]     s_raddr,
  input  logic [TID_W-1:0]  s_rdata
);

  localparam int T = MAX_THREADS_PER_GROUP;

  state_t            state_r, state_nxt;
  mode_t             mode_r;
  logic [GID_W-1:0]  gid_r, key_r;
  logic [TID_W-1:0]  tid_r;
  logic [GW-1:0]     g_r, free_r;
  logic              free_found_r;
  logic [HW-1:0]     head_r;
  logic [CW-1:0]     cnt_r, i_r;
  logic [MAX_GROUPS-1:0] valid_r;
  res_t              res_r, out_r;
  logic              out_valid_r;

  logic [GID_W-1:0]  gd_key;
  logic [HW-1:0]     gd_head;
  logic [CW-1:0]     gd_cnt;
  logic              last_g, gmatch, free_here, hmatch, create_ok, out_free, in_acc;
  logic              single, q_full, scan_end;
  logic [GW-1:0]     fidx;
  logic [HW-1:0]     nh;

  function automatic logic [HW-1:0] wrap(input logic [HW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(off);
    if (s >= (CW+1)'(T)) begin
      s = s - (CW+1)'(T);
    end
    return HW'(s);
  endfunction

  function automatic logic [AW-1:0] saddr(input logic [GW-1:0] g, input logic [HW-1:0] p);
    return AW'(AW'(g) * AW'(T)) + AW'(p);
  endfunction

  assign {gd_key, gd_head, gd_cnt} = g_rdata;
  assign last_g    = (g_r == GW'(MAX_GROUPS - 1));
  assign gmatch    = valid_r[g_r] && (gd_key == gid_r);
  assign free_here = !valid_r[g_r];
  assign hmatch    = (s_rdata == tid_r);
  assign create_ok = free_found_r || free_here;
  assign fidx      = free_found_r ? free_r : g_r;
  assign nh        = wrap(head_r, CW'(1));
  assign single    = (cnt_r <= CW'(1));
  assign q_full    = (cnt_r >= CW'(T));
  assign scan_end  = (i_r == cnt_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (mode_t'(in_mode) == MODE_NONE) ? S_DONE : S_GRD;
        end
      end
      S_GRD: state_nxt = S_GCHK;
      S_GCHK: begin
        if (mode_r == MODE_SWITCH) begin
          if (valid_r[g_r]) state_nxt = S_HCHK;
          else              state_nxt = last_g ? S_DONE : S_GRD;
        end else if (gmatch) begin
          state_nxt = (mode_r == MODE_CREATE) ? S_DRD : S_DEL;
        end else begin
          state_nxt = last_g ? S_DONE : S_GRD;
        end
      end
      S_HCHK: begin
        if (hmatch) state_nxt = single ? S_DONE : S_SROT;
        else        state_nxt = last_g ? S_DONE : S_GRD;
      end
      S_DRD:  state_nxt = scan_end ? S_DONE : S_DCHK;
      S_DCHK: state_nxt = hmatch ? S_DONE : S_DRD;
      S_DEL:  state_nxt = single ? S_DONE : S_WAKE;
      S_SROT: state_nxt = S_WAKE;
      S_WAKE: state_nxt = S_DONE;
      S_DONE: state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    g_we     = 1'b0;
    g_waddr  = g_r;
    g_wdata  = {key_r, head_r, cnt_r};
    g_raddr  = g_r;
    s_we     = 1'b0;
    s_waddr  = saddr(g_r, wrap(head_r, cnt_r));
    s_wdata  = tid_r;
    s_raddr  = saddr(g_r, wrap(head_r, i_r));
    unique case (state_r)
      S_IDLE: in_stall = 1'b0;
      S_GCHK: begin
        s_raddr = saddr(g_r, gd_head);
        if (mode_r == MODE_CREATE && !gmatch && last_g && create_ok) begin
          g_we    = 1'b1;
          g_waddr = fidx;
          g_wdata = {gid_r, HW'(0), CW'(1)};
          s_we    = 1'b1;
          s_waddr = saddr(fidx, HW'(0));
        end
      end
      S_DRD: begin
        if (scan_end && !q_full) begin
          s_we    = 1'b1;
          g_we    = 1'b1;
          g_wdata = {key_r, head_r, CW'(cnt_r + CW'(1))};
        end
      end
      S_DEL: begin
        g_we    = 1'b1;
        g_wdata = single ? {key_r, HW'(0), CW'(0)} : {key_r, nh, CW'(cnt_r - CW'(1))};
        s_raddr = saddr(g_r, nh);
      end
      S_SROT: begin
        s_we    = 1'b1;
        g_we    = 1'b1;
        g_wdata = {key_r, nh, cnt_r};
        s_raddr = saddr(g_r, nh);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_GCHK && mode_r == MODE_CREATE && !gmatch && last_g && create_ok) begin
        valid_r[fidx] <= 1'b1;
      end
      if (state_r == S_DEL && single) begin
        valid_r[g_r] <= 1'b0;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r       <= mode_t'(in_mode);
      gid_r        <= in_group_id;
      tid_r        <= in_thread_id;
      g_r          <= '0;
      free_found_r <= 1'b0;
      res_r        <= '0;
      if (mode_t'(in_mode) == MODE_NONE) res_r.status <= ST_NOTHING;
    end
    if ((state_r == S_GCHK || state_r == S_HCHK) && state_nxt == S_GRD) begin
      g_r <= g_r + GW'(1);
    end
    unique case (state_r)
      S_GCHK: begin
        key_r  <= gd_key;
        head_r <= gd_head;
        cnt_r  <= gd_cnt;
        i_r    <= '0;
        if (mode_r == MODE_CREATE && free_here && !free_found_r) begin
          free_found_r <= 1'b1;
          free_r       <= g_r;
        end
        if (last_g) begin
          if (mode_r == MODE_CREATE && !gmatch) begin
            if (create_ok) res_r.group_created <= 1'b1;
            else           res_r.status        <= ST_TABLE_FULL;
          end else if (mode_r == MODE_DELETE && !gmatch) begin
            res_r.status <= ST_NOT_FOUND;
          end else if (mode_r == MODE_SWITCH && !valid_r[g_r]) begin
            res_r.status <= ST_NOT_FOUND;
          end
        end
      end
      S_HCHK: begin
        if (hmatch && single)         res_r.status <= ST_NOTHING;
        else if (!hmatch && last_g)   res_r.status <= ST_NOT_FOUND;
      end
      S_DRD: begin
        if (scan_end) begin
          if (q_full) res_r.status        <= ST_QUEUE_FULL;
          else        res_r.caller_sleeps <= (cnt_r != CW'(0));
        end
      end
      S_DCHK: begin
        if (hmatch) res_r.status <= ST_DUPLICATE;
        else        i_r <= i_r + CW'(1);
      end
      S_DEL: begin
        if (single) res_r.group_removed <= 1'b1;
        else        res_r.wake_valid    <= 1'b1;
      end
      S_SROT: begin
        res_r.wake_valid    <= 1'b1;
        res_r.caller_sleeps <= 1'b1;
      end
      S_WAKE: res_r.wake_thread <= s_rdata;
      S_DONE: begin
        if (out_free) out_r <= res_r;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

>>> rtl/grouped_round_robin_thread_queues_unit.sv
// Grouped round-robin thread queues: one command beat in, one result beat out.
// From accept to result the unit visits group slots in turn (on switch each valid slot also gets a
// head check), then on create into an existing group checks its queue entries and appends, then
// does the update and registers the result. The next beat is taken once the result is registered;
// a stalled result holds the unit. Reset clears slot valid bits and control only.
module grouped_round_robin_thread_queues_unit import grrq_pkg::*; #(
  parameter int MAX_GROUPS            = MAX_GROUPS_DEF,
  parameter int MAX_THREADS_PER_GROUP = MAX_THREADS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [GID_W-1:0]  in_group_id,
  input  logic [TID_W-1:0]  in_thread_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic              out_wake_valid,
  output logic [TID_W-1:0]  out_wake_thread,
  output logic              out_caller_sleeps,
  output logic              out_group_created,
  output logic              out_group_removed
);

  localparam int GW  = $clog2(MAX_GROUPS);
  localparam int HW  = $clog2(MAX_THREADS_PER_GROUP);
  localparam int CW  = $clog2(MAX_THREADS_PER_GROUP + 1);
  localparam int SD  = MAX_GROUPS * MAX_THREADS_PER_GROUP;
  localparam int AW  = $clog2(SD);
  localparam int GMW = GID_W + HW + CW;

  res_t             res;
  logic             g_we, s_we;
  logic [GW-1:0]    g_waddr, g_raddr;
  logic [GMW-1:0]   g_wdata, g_rdata;
  logic [AW-1:0]    s_waddr, s_raddr;
  logic [TID_W-1:0] s_wdata, s_rdata;

  grrq_ctrl #(
    .MAX_GROUPS(MAX_GROUPS),
    .MAX_THREADS_PER_GROUP(MAX_THREADS_PER_GROUP)
  ) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode, .in_group_id, .in_thread_id,
    .out_valid, .out_stall, .out_res(res),
    .g_we, .g_waddr, .g_wdata, .g_raddr, .g_rdata,
    .s_we, .s_waddr, .s_wdata, .s_raddr, .s_rdata
  );

  grrq_ram #(.W(GMW), .D(MAX_GROUPS)) u_gtab (
    .clk, .we(g_we), .waddr(g_waddr), .wdata(g_wdata), .raddr(g_raddr), .rdata(g_rdata)
  );

  grrq_ram #(.W(TID_W), .D(SD)) u_store (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );

  assign out_status        = res.status;
  assign out_wake_valid    = res.wake_valid;
  assign out_wake_thread   = res.wake_thread;
  assign out_caller_sleeps = res.caller_sleeps;
  assign out_group_created = res.group_created;
  assign out_group_removed = res.group_removed;

endmodule

>>> rtl/grrq_checker.sv
// grrq_checker: port-level assertions for the thread queue unit, plus its bind.
// Depends on grrq_pkg and grouped_round_robin_thread_queues_unit.
module grrq_checker import grrq_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [STAT_W-1:0] out_status,
  input logic              out_wake_valid,
  input logic [TID_W-1:0]  out_wake_thread,
  input logic              out_caller_sleeps,
  input logic              out_group_created
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepted beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) &&
                                  $stable(out_wake_thread)))
    else $error("stalled result beat changed");

  a_wake_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_wake_valid) |-> (out_status == ST_OK))
    else $error("wake with error status");

  a_create_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_group_created) |-> (!out_caller_sleeps && !out_wake_valid))
    else $error("new group with sleep or wake");

endmodule

bind grouped_round_robin_thread_queues_unit grrq_checker u_grrq_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_status,
  .out_wake_valid, .out_wake_thread, .out_caller_sleeps, .out_group_created
);
